[sv/lsbse_pkg.sv]
// Package for the LSB audio stego embedder: constants, codes and pipeline types.
`timescale 1ns / 1ps

package lsbse_pkg;

	// Message store geometry
	localparam int MSG_DEPTH = 4096;
	localparam int MSG_AW    = $clog2(MSG_DEPTH);
	localparam int LIDX_W    = $clog2(MSG_DEPTH + 1);
	localparam int LEN_W     = 13;

	// Carrier position and payload offset widths
	localparam int POS_W  = 25;
	localparam int RW     = MSG_AW + 5;
	localparam int LEN4_W = LIDX_W + 2;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// Flag layout
	localparam int FLAG_LEN = 24;
	localparam logic [7:0] CHAR_F   = 8'h46;
	localparam logic [7:0] CHAR_L   = 8'h4C;
	localparam logic [7:0] CHAR_ONE = 8'h31;

	typedef enum logic [1:0] {
		KIND_LOAD    = 2'd0,
		KIND_CARRIER = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CFG_MODE = 2'd0,
		CFG_GAP  = 2'd1,
		CFG_LEN  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_EVERY = 2'd0,
		MODE_ALT   = 2'd1,
		MODE_TWO   = 2'd2,
		MODE_GAP   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		PH_BEFORE  = 3'd0,
		PH_START   = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_END     = 3'd3,
		PH_AFTER   = 3'd4
	} phase_t;

	// What the output stage does to the carrier byte
	typedef enum logic [1:0] {
		ACT_PASS = 2'd0,
		ACT_FLAG = 2'd1,
		ACT_MSG1 = 2'd2,
		ACT_MSG2 = 2'd3
	} act_t;

	// Region boundaries derived from the configuration
	typedef struct packed {
		logic [POS_W-1:0]  b_start;
		logic [POS_W-1:0]  b_payload;
		logic [POS_W-1:0]  b_end;
		logic [POS_W-1:0]  b_after;
		logic [LEN4_W-1:0] len4;
	} thr_t;

	// Decoded request held between the input and the result register
	typedef struct packed {
		act_t       act;
		logic       flag_bit;
		logic [2:0] bit_pos;
		phase_t     phase;
		logic [7:0] sample;
	} s1_t;

endpackage

[sv/lsb_audio_stego_embedder.sv]
// Top level of the LSB audio stego embedder: message store, position tracking, bit insertion.
`timescale 1ns / 1ps

// Usage:
//   Item channel (item_valid / item_stall, kind, message_byte, sample_byte):
//   kind 0 loads a message byte, kind 1 is a carrier byte, kind 2 restarts
//   the run (position and load index cleared, store kept).
//   Result channel (result_valid / result_stall, sample_out, embed_phase):
//   one result per carrier byte, in order; other kinds give none.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): 0 mode,
//   1 gap bytes, 2 message length; cfg_ready is always high. Write only
//   while idle; the item side stalls after each write while the region
//   boundaries are recomputed.
//   Pipeline: the accepting edge of a carrier byte loads the decode stage
//   and the store read register; the result register loads from them when
//   it can advance, and a receiver stall holds it.
//   Throughput: one item per cycle while item_stall is low; the store has
//   one write and one read port, and loads and carrier reads never contend.
//   Reset: control registers cleared but the config-dirty flag set; store
//   contents undefined until loaded; the item side stalls until thr_q loads.
//   Receiver stall: results hold; requests are still taken until a carrier
//   byte sits in the decode stage, then item_stall rises until the result
//   register drains.

module lsb_audio_stego_embedder import lsbse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  message_byte,
	input  logic [7:0]  sample_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  sample_out,
	output logic [2:0]  embed_phase,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic [1:0]        mode_q;
	logic [23:0]       gap_q;
	logic [LEN_W-1:0]  len_q;
	logic              cfg_dirty_q;
	thr_t              thr_q;
	thr_t              thr_d;

	logic [LIDX_W-1:0] load_index_q;
	logic [POS_W-1:0]  pos_q;

	logic [7:0]        msg_mem [MSG_DEPTH];
	logic [7:0]        rdata_q;
	logic [MSG_AW-1:0] raddr;

	logic              valid_s1;
	s1_t               s1_d;
	s1_t               s1_q_s1;

	logic              adv1;
	logic              adv2;
	logic              item_acc;
	logic              cfg_acc;
	logic              wr_en;

	logic [7:0]        ob;
	logic [LEN_W-1:0]  len_c;
	logic [RW-1:0]     span;
	logic [POS_W-1:0]  base;
	logic [RW-1:0]     r2;
	logic [4:0]        rf;
	logic [7:0]        fchar;

	// Handshakes
	assign cfg_ready  = 1'b1;
	assign cfg_acc    = cfg_valid && cfg_ready;
	assign adv2       = !result_valid || !result_stall;
	assign adv1       = !valid_s1 || adv2;
	assign item_stall = !adv1 || cfg_dirty_q;
	assign item_acc   = item_valid && !item_stall;
	assign wr_en      = item_acc && (kind_t'(kind) == KIND_LOAD)
		&& (load_index_q < LIDX_W'(MSG_DEPTH));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 2'd0;
			gap_q       <= 24'd0;
			len_q       <= '0;
			cfg_dirty_q <= 1'b1;
		end else begin
			cfg_dirty_q <= cfg_acc;
			if (cfg_acc) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_MODE: mode_q <= cfg_data[1:0];
					CFG_GAP:  gap_q  <= cfg_data;
					CFG_LEN:  len_q  <= cfg_data[LEN_W-1:0];
					default:  ;
				endcase
			end
		end
	end

	// Derive region boundaries from the configuration
	always_comb begin
		len_c = (len_q > LEN_W'(MSG_DEPTH)) ? LEN_W'(MSG_DEPTH) : len_q;
		case (mode_t'(mode_q))
			MODE_ALT: span = RW'({len_c, 4'b0});
			MODE_TWO: span = (RW'({len_c, 2'b0}) + RW'(7)) & ~RW'(7);
			default:  span = RW'({len_c, 3'b0});
		endcase
		base = (mode_t'(mode_q) == MODE_GAP)
			? ((POS_W'(gap_q) + POS_W'(7)) & ~POS_W'(7)) : '0;
		thr_d.b_start   = base;
		thr_d.b_payload = base + POS_W'(FLAG_LEN);
		thr_d.b_end     = thr_d.b_payload + POS_W'(span);
		thr_d.b_after   = thr_d.b_end + POS_W'(FLAG_LEN);
		thr_d.len4      = LEN4_W'({len_c, 2'b0});
	end

	always_ff @(posedge clk) begin
		thr_q <= thr_d;
	end

	// Run state: load index and carrier position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_index_q <= '0;
			pos_q        <= '0;
		end else if (item_acc) begin
			case (kind_t'(kind))
				KIND_LOAD: begin
					if (wr_en) load_index_q <= load_index_q + 1'b1;
				end
				KIND_CARRIER: begin
					if (pos_q != POS_MAX) pos_q <= pos_q + 1'b1;
				end
				KIND_RESTART: begin
					load_index_q <= '0;
					pos_q        <= '0;
				end
				default: ;
			endcase
		end
	end

	// Decode the current carrier position into an action and a store address
	always_comb begin
		s1_d.sample   = sample_byte;
		s1_d.act      = ACT_PASS;
		s1_d.flag_bit = 1'b0;
		s1_d.bit_pos  = 3'd0;
		raddr         = '0;
		r2            = pos_q[RW-1:0] - thr_q.b_payload[RW-1:0];

		if (pos_q < thr_q.b_start)        s1_d.phase = PH_BEFORE;
		else if (pos_q < thr_q.b_payload) s1_d.phase = PH_START;
		else if (pos_q < thr_q.b_end)     s1_d.phase = PH_PAYLOAD;
		else if (pos_q < thr_q.b_after)   s1_d.phase = PH_END;
		else                              s1_d.phase = PH_AFTER;

		// Flag bits: offset within the flag fits in five bits
		rf = pos_q[4:0] - ((s1_d.phase == PH_START) ? thr_q.b_start[4:0] : thr_q.b_end[4:0]);
		case (rf[4:3])
			2'd0:    fchar = CHAR_F;
			2'd1:    fchar = CHAR_L;
			default: fchar = CHAR_ONE + 8'(mode_q);
		endcase

		case (s1_d.phase)
			PH_START, PH_END: begin
				s1_d.act      = ACT_FLAG;
				s1_d.flag_bit = fchar[rf[2:0]];
			end
			PH_PAYLOAD: begin
				case (mode_t'(mode_q))
					MODE_ALT: begin
						if (!r2[0]) s1_d.act = ACT_MSG1;
						raddr        = r2[MSG_AW+3:4];
						s1_d.bit_pos = r2[3:1];
					end
					MODE_TWO: begin
						if (r2 < RW'(thr_q.len4)) s1_d.act = ACT_MSG2;
						raddr        = r2[MSG_AW+1:2];
						s1_d.bit_pos = {r2[1:0], 1'b0};
					end
					default: begin
						s1_d.act     = ACT_MSG1;
						raddr        = r2[MSG_AW+2:3];
						s1_d.bit_pos = r2[2:0];
					end
				endcase
			end
			default: ;
		endcase
	end

	// Message store: load writes, carrier reads
	always_ff @(posedge clk) begin
		if (wr_en) msg_mem[load_index_q[MSG_AW-1:0]] <= message_byte;
		if (adv1) rdata_q <= msg_mem[raddr];
	end

	// Decode stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= item_acc && (kind_t'(kind) == KIND_CARRIER);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) s1_q_s1 <= s1_d;
	end

	// Insert the selected bits into the carrier byte
	always_comb begin
		case (s1_q_s1.act)
			ACT_FLAG: ob = {s1_q_s1.sample[7:1], s1_q_s1.flag_bit};
			ACT_MSG1: ob = {s1_q_s1.sample[7:1], rdata_q[s1_q_s1.bit_pos]};
			ACT_MSG2: ob = {s1_q_s1.sample[7:2], rdata_q[s1_q_s1.bit_pos + 3'd1],
				rdata_q[s1_q_s1.bit_pos]};
			default:  ob = s1_q_s1.sample;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv2) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			sample_out  <= ob;
			embed_phase <= s1_q_s1.phase;
		end
	end

	// Checks
	a_flag_act: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (s1_q_s1.phase == PH_START || s1_q_s1.phase == PH_END)
		|-> s1_q_s1.act == ACT_FLAG)
		else $error("flag region decoded without flag action");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && kind_t'(kind) == KIND_RESTART
		|=> pos_q == '0 && load_index_q == '0)
		else $error("restart did not clear run state");

	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_index_q <= LIDX_W'(MSG_DEPTH))
		else $error("load index beyond store depth");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_dirty_q && !valid_s1 |-> !item_stall)
		else $error("item side stalled with empty pipeline");

endmodule
